[hdl/cfgtok_pkg.sv]
// shared types and codes for the configuration text tokenizer
// no dependencies; used by config_text_tokenizer
`default_nettype none

package cfgtok_pkg;

    // width of the running byte offset; token fields carry its low 16 bits
    localparam int OFFSET_BITS = 16;

    typedef logic [OFFSET_BITS-1:0] ofs_t;

    // one input transaction
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    // one result transaction
    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        last_of_run;
    } out_item_t;

    // token kinds
    localparam logic [4:0] KIND_END     = 5'd0;
    localparam logic [4:0] KIND_IDENT   = 5'd1;
    localparam logic [4:0] KIND_STRING  = 5'd2;
    localparam logic [4:0] KIND_NUMBER  = 5'd3;
    localparam logic [4:0] KIND_EQUAL   = 5'd7;
    localparam logic [4:0] KIND_COLON   = 5'd8;
    localparam logic [4:0] KIND_SEMI    = 5'd9;
    localparam logic [4:0] KIND_LESS    = 5'd10;
    localparam logic [4:0] KIND_GREATER = 5'd11;
    localparam logic [4:0] KIND_LBRACK  = 5'd12;
    localparam logic [4:0] KIND_RBRACK  = 5'd13;
    localparam logic [4:0] KIND_COMMA   = 5'd14;
    localparam logic [4:0] KIND_TILDE   = 5'd15;
    localparam logic [4:0] KIND_BADNUM  = 5'd16;
    localparam logic [4:0] KIND_BADCHAR = 5'd17;

    // scanner modes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_IDENT   = 3'd1;
    localparam logic [2:0] MODE_STRING  = 3'd2;
    localparam logic [2:0] MODE_NUMBER  = 3'd3;
    localparam logic [2:0] MODE_SLASH   = 3'd4;
    localparam logic [2:0] MODE_COMMENT = 3'd5;

    // keyword prefix codes
    localparam logic [1:0] KW_NONE  = 2'd0;
    localparam logic [1:0] KW_TRUE  = 2'd1;
    localparam logic [1:0] KW_FALSE = 2'd2;
    localparam logic [1:0] KW_NULL  = 2'd3;

    // number flag bit positions
    localparam int NF_POINT = 0;
    localparam int NF_EXP   = 1;
    localparam int NF_ESIGN = 2;
    localparam int NF_DIGIT = 3;

endpackage

`default_nettype wire

[hdl/config_text_tokenizer.sv]
// streaming tokenizer for json-like configuration text, one byte per transaction
// depends on cfgtok_pkg for payload structs, token kinds and scanner modes
//
// path: a byte waits in the input register, is scanned, and its tokens enter the token queue
// throughput: one byte per cycle while bytes average at most one token each; the queue
//   drains one entry per cycle while token_stall is low, and the input stalls unless three
//   entries are free after this cycle's pop, so tokens beyond one per byte back up the input
// reset: asynchronous active-low; scanner idle, offset zero, queue empty
`default_nettype none

module config_text_tokenizer (
    input  wire                   clk,
    input  wire                   rst_n,
    // byte channel
    input  wire                   byte_valid,
    output logic                  byte_stall,
    input  wire cfgtok_pkg::in_item_t byte_data,
    // token channel
    output logic                  token_valid,
    input  wire                   token_stall,
    output cfgtok_pkg::out_item_t token_data
);

    // one candidate token before compaction
    typedef struct packed {
        logic                 valid;
        logic [4:0]           kind;
        cfgtok_pkg::ofs_t     start;
        cfgtok_pkg::ofs_t     len;
    } res_t;

    // what an idle scanner does with a fresh byte
    typedef struct packed {
        res_t                 r;
        logic [2:0]           mode;
        cfgtok_pkg::ofs_t     bgn;
        logic [1:0]           kw;
        logic [3:0]           fl;
        logic                 err;
    } take_t;

    // ------------------------------------------------------------------
    // character classes and tables
    // ------------------------------------------------------------------
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            "=":     k = cfgtok_pkg::KIND_EQUAL;
            ":":     k = cfgtok_pkg::KIND_COLON;
            ";":     k = cfgtok_pkg::KIND_SEMI;
            "<":     k = cfgtok_pkg::KIND_LESS;
            ">":     k = cfgtok_pkg::KIND_GREATER;
            "[":     k = cfgtok_pkg::KIND_LBRACK;
            "]":     k = cfgtok_pkg::KIND_RBRACK;
            ",":     k = cfgtok_pkg::KIND_COMMA;
            "~":     k = cfgtok_pkg::KIND_TILDE;
            default: k = cfgtok_pkg::KIND_END;
        endcase
        return k;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] kw);
        logic [2:0] n;
        unique case (kw)
            cfgtok_pkg::KW_TRUE:  n = 3'd4;
            cfgtok_pkg::KW_FALSE: n = 3'd5;
            cfgtok_pkg::KW_NULL:  n = 3'd4;
            default:              n = 3'd0;
        endcase
        return n;
    endfunction

    // keyword letter at position i; only called with i below the keyword length
    function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] i);
        logic [7:0] ch;
        ch = 8'd0;
        unique case (kw)
            cfgtok_pkg::KW_TRUE: begin
                case (i)
                    3'd0:    ch = "t";
                    3'd1:    ch = "r";
                    3'd2:    ch = "u";
                    default: ch = "e";
                endcase
            end
            cfgtok_pkg::KW_FALSE: begin
                case (i)
                    3'd0:    ch = "f";
                    3'd1:    ch = "a";
                    3'd2:    ch = "l";
                    3'd3:    ch = "s";
                    default: ch = "e";
                endcase
            end
            cfgtok_pkg::KW_NULL: begin
                case (i)
                    3'd0:    ch = "n";
                    3'd1:    ch = "u";
                    default: ch = "l";
                endcase
            end
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [15:0] to_w16(input cfgtok_pkg::ofs_t x);
        logic [cfgtok_pkg::OFFSET_BITS+15:0] t;
        t = {16'd0, x};
        return t[15:0];
    endfunction

    // ------------------------------------------------------------------
    // closing an open token at offset q
    // ------------------------------------------------------------------
    function automatic res_t flush_f(input logic [2:0] m, input cfgtok_pkg::ofs_t bgn,
                                     input logic [1:0] kw, input logic [3:0] fl,
                                     input cfgtok_pkg::ofs_t q);
        res_t             r;
        cfgtok_pkg::ofs_t len;
        logic             bad;
        len     = q - bgn;
        r       = '0;
        r.start = bgn;
        r.len   = len;
        case (m)
            cfgtok_pkg::MODE_IDENT: begin
                r.valid = 1'b1;
                if ((kw != cfgtok_pkg::KW_NONE) && (len == cfgtok_pkg::ofs_t'(kw_len(kw))))
                    r.kind = cfgtok_pkg::KIND_NUMBER + {3'd0, kw};
                else
                    r.kind = cfgtok_pkg::KIND_IDENT;
            end
            cfgtok_pkg::MODE_STRING: begin
                r.valid = 1'b1;
                r.kind  = cfgtok_pkg::KIND_STRING;
            end
            cfgtok_pkg::MODE_NUMBER: begin
                bad = (len == '0)
                    || (fl[cfgtok_pkg::NF_POINT] && (len == cfgtok_pkg::ofs_t'(1)))
                    || (fl[cfgtok_pkg::NF_EXP] &&
                        ((len == cfgtok_pkg::ofs_t'(1)) || !fl[cfgtok_pkg::NF_DIGIT]));
                r.valid = 1'b1;
                r.kind  = bad ? cfgtok_pkg::KIND_BADNUM : cfgtok_pkg::KIND_NUMBER;
            end
            cfgtok_pkg::MODE_SLASH: begin
                r.valid = 1'b1;
                r.kind  = cfgtok_pkg::KIND_BADCHAR;
                r.len   = cfgtok_pkg::ofs_t'(1);
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // idle scanner meets byte c at offset p
    // ------------------------------------------------------------------
    function automatic take_t take_f(input logic [7:0] c, input cfgtok_pkg::ofs_t p);
        take_t t;
        t      = '0;
        t.mode = cfgtok_pkg::MODE_IDLE;
        t.bgn  = p;
        if (is_space(c)) begin
            t.mode = cfgtok_pkg::MODE_IDLE;
        end else if (is_alpha(c) || (c == "_")) begin
            t.mode = cfgtok_pkg::MODE_IDENT;
            t.kw   = (c == "t") ? cfgtok_pkg::KW_TRUE :
                     (c == "f") ? cfgtok_pkg::KW_FALSE :
                     (c == "n") ? cfgtok_pkg::KW_NULL : cfgtok_pkg::KW_NONE;
        end else if (c == "\"") begin
            t.mode = cfgtok_pkg::MODE_STRING;
            t.bgn  = p + cfgtok_pkg::ofs_t'(1);
        end else if (is_digit(c) || (c == ".") || (c == "+") || (c == "-")) begin
            t.mode = cfgtok_pkg::MODE_NUMBER;
            if (c == "+")
                t.bgn = p + cfgtok_pkg::ofs_t'(1);
            t.fl[cfgtok_pkg::NF_DIGIT] = is_digit(c);
            t.fl[cfgtok_pkg::NF_POINT] = (c == ".");
        end else if (c == "/") begin
            t.mode = cfgtok_pkg::MODE_SLASH;
        end else if (punct_kind(c) != cfgtok_pkg::KIND_END) begin
            t.r.valid = 1'b1;
            t.r.kind  = punct_kind(c);
            t.r.start = p;
            t.r.len   = cfgtok_pkg::ofs_t'(1);
        end else begin
            t.r.valid = 1'b1;
            t.r.kind  = cfgtok_pkg::KIND_BADCHAR;
            t.r.start = p;
            t.r.len   = cfgtok_pkg::ofs_t'(1);
            t.err     = 1'b1;
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------
    logic                 stage_valid_reg;
    cfgtok_pkg::in_item_t stage_reg;
    logic                 advance;
    logic                 byte_take;

    // scanner state
    logic [2:0]           mode_reg,   mode_next;
    cfgtok_pkg::ofs_t     offset_reg, offset_next;
    cfgtok_pkg::ofs_t     begin_reg,  begin_next;
    logic [1:0]           kw_reg,     kw_next;
    logic [3:0]           flags_reg,  flags_next;
    logic                 halted_reg, halted_next;

    // token queue, four entries
    cfgtok_pkg::out_item_t queue_mem [4];
    logic [1:0]            rd_ptr_reg;
    logic [1:0]            wr_ptr_reg;
    logic [2:0]            count_reg;
    logic                  pop;
    logic                  room;
    cfgtok_pkg::out_item_t packed_item [4];
    logic [2:0]            push_n;

    assign pop         = token_valid && !token_stall;
    // room for three more tokens once this cycle's pop is counted
    assign room        = (count_reg <= 3'd1) || ((count_reg == 3'd2) && pop);
    assign advance     = stage_valid_reg && room;
    assign byte_stall  = stage_valid_reg && !advance;
    assign byte_take   = byte_valid && !byte_stall;
    assign token_valid = (count_reg != 3'd0);
    assign token_data  = queue_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (byte_take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            stage_reg <= byte_data;
        end
    end

    // ------------------------------------------------------------------
    // single-pass scan of the registered byte
    // candidate slots in emit order: closed token, token started by this
    // byte, token closed by end of text, end token
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [7:0]       c;
        logic             eot;
        cfgtok_pkg::ofs_t p;
        cfgtok_pkg::ofs_t q;
        cfgtok_pkg::ofs_t idx;
        logic [2:0]       m;
        cfgtok_pkg::ofs_t bgn;
        logic [1:0]       kw;
        logic [3:0]       fl;
        logic [3:0]       nf;
        logic             acc;
        logic             hlt;
        logic             use_take;
        logic             do_reset;
        take_t            tk;
        res_t             slot [4];
        logic             later;
        logic [1:0]       wi;

        c        = stage_reg.text_byte;
        eot      = stage_reg.end_of_text;
        p        = offset_reg;
        q        = offset_reg + cfgtok_pkg::ofs_t'(1);
        idx      = p - begin_reg;
        m        = mode_reg;
        bgn      = begin_reg;
        kw       = kw_reg;
        fl       = flags_reg;
        nf       = flags_reg;
        acc      = 1'b0;
        hlt      = halted_reg;
        use_take = 1'b0;
        do_reset = 1'b0;
        later    = 1'b0;
        wi       = 2'd0;
        tk       = take_f(c, p);
        for (int i = 0; i < 4; i++)
            slot[i] = '0;

        if (halted_reg)
        begin
            // bytes are only counted until end of text
            if ((c == 8'd0) || eot)
            begin
                slot[3].valid = 1'b1;
                slot[3].kind  = cfgtok_pkg::KIND_END;
                slot[3].start = (c == 8'd0) ? p : q;
                do_reset      = 1'b1;
            end
        end
        else if (c == 8'd0)
        begin
            // nul ends the text at its own offset
            slot[0]       = flush_f(m, bgn, kw, fl, p);
            slot[3].valid = 1'b1;
            slot[3].kind  = cfgtok_pkg::KIND_END;
            slot[3].start = p;
            do_reset      = 1'b1;
        end
        else
        begin
            case (m)
                cfgtok_pkg::MODE_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c) || (c == "_"))
                    begin
                        if ((kw == cfgtok_pkg::KW_NONE)
                            || (idx >= cfgtok_pkg::ofs_t'(kw_len(kw)))
                            || (kw_char(kw, idx[2:0]) != c))
                            kw = cfgtok_pkg::KW_NONE;
                    end
                    else
                    begin
                        slot[0]  = flush_f(m, bgn, kw, fl, p);
                        m        = cfgtok_pkg::MODE_IDLE;
                        use_take = 1'b1;
                    end
                end
                cfgtok_pkg::MODE_STRING:
                begin
                    if (c == "\"")
                    begin
                        slot[0] = flush_f(m, bgn, kw, fl, p);
                        m       = cfgtok_pkg::MODE_IDLE;
                    end
                end
                cfgtok_pkg::MODE_NUMBER:
                begin
                    // does the number go on over this byte
                    if (is_digit(c))
                    begin
                        acc                         = 1'b1;
                        nf[cfgtok_pkg::NF_DIGIT]    = 1'b1;
                    end
                    else if (c == ".")
                    begin
                        acc                         = !fl[cfgtok_pkg::NF_POINT];
                        nf[cfgtok_pkg::NF_POINT]    = 1'b1;
                        nf[cfgtok_pkg::NF_DIGIT]    = 1'b0;
                    end
                    else if ((c == "e") || (c == "E"))
                    begin
                        acc                         = !fl[cfgtok_pkg::NF_EXP];
                        nf[cfgtok_pkg::NF_EXP]      = 1'b1;
                        nf[cfgtok_pkg::NF_DIGIT]    = 1'b0;
                    end
                    else if (((c == "+") || (c == "-")) && fl[cfgtok_pkg::NF_EXP]
                             && !fl[cfgtok_pkg::NF_ESIGN])
                    begin
                        acc                         = 1'b1;
                        nf[cfgtok_pkg::NF_ESIGN]    = 1'b1;
                        nf[cfgtok_pkg::NF_DIGIT]    = 1'b0;
                    end

                    if (acc)
                    begin
                        fl = nf;
                    end
                    else
                    begin
                        slot[0] = flush_f(m, bgn, kw, fl, p);
                        m       = cfgtok_pkg::MODE_IDLE;
                        if (slot[0].kind == cfgtok_pkg::KIND_BADNUM)
                            hlt = 1'b1;
                        else
                            use_take = 1'b1;
                    end
                end
                cfgtok_pkg::MODE_SLASH:
                begin
                    if (c == "/")
                    begin
                        m = cfgtok_pkg::MODE_COMMENT;
                    end
                    else
                    begin
                        // lone slash
                        slot[0] = flush_f(m, bgn, kw, fl, p);
                        m       = cfgtok_pkg::MODE_IDLE;
                        hlt     = 1'b1;
                    end
                end
                cfgtok_pkg::MODE_COMMENT:
                begin
                    if (c == 8'd10)
                        m = cfgtok_pkg::MODE_IDLE;
                end
                default:
                begin
                    // idle, and the two unused codes
                    use_take = 1'b1;
                end
            endcase

            if (use_take)
            begin
                slot[1] = tk.r;
                m       = tk.mode;
                bgn     = tk.bgn;
                kw      = tk.kw;
                fl      = tk.fl;
                hlt     = hlt || tk.err;
            end

            if (eot)
            begin
                // open token and end token close just past this byte
                if (!hlt)
                    slot[2] = flush_f(m, bgn, kw, fl, q);
                slot[3].valid = 1'b1;
                slot[3].kind  = cfgtok_pkg::KIND_END;
                slot[3].start = q;
                do_reset      = 1'b1;
            end
        end

        if (do_reset)
        begin
            mode_next   = cfgtok_pkg::MODE_IDLE;
            offset_next = '0;
            begin_next  = '0;
            kw_next     = cfgtok_pkg::KW_NONE;
            flags_next  = '0;
            halted_next = 1'b0;
        end
        else
        begin
            mode_next   = hlt ? cfgtok_pkg::MODE_IDLE : m;
            offset_next = q;
            begin_next  = bgn;
            kw_next     = kw;
            flags_next  = fl;
            halted_next = hlt;
        end

        // compact the valid slots, marking the last of the run
        push_n = 3'd0;
        for (int i = 0; i < 4; i++)
            packed_item[i] = '0;
        for (int i = 0; i < 4; i++)
        begin
            later = 1'b0;
            for (int j = i + 1; j < 4; j++)
                later = later || slot[j].valid;
            if (slot[i].valid)
            begin
                wi                           = push_n[1:0];
                packed_item[wi].token_kind   = slot[i].kind;
                packed_item[wi].token_start  = to_w16(slot[i].start);
                packed_item[wi].token_length = to_w16(slot[i].len);
                packed_item[wi].last_of_run  = !later;
                push_n                       = push_n + 3'd1;
            end
        end
        if (!advance)
            push_n = 3'd0;
    end

    // ------------------------------------------------------------------
    // scanner state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= cfgtok_pkg::MODE_IDLE;
            offset_reg <= '0;
            begin_reg  <= '0;
            kw_reg     <= cfgtok_pkg::KW_NONE;
            flags_reg  <= '0;
            halted_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            begin_reg  <= begin_next;
            kw_reg     <= kw_next;
            flags_reg  <= flags_next;
            halted_reg <= halted_next;
        end
    end

    // ------------------------------------------------------------------
    // token queue
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            wr_ptr_reg <= wr_ptr_reg + push_n[1:0];
            count_reg  <= count_reg + push_n - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (3'(k) < push_n)
            begin
                queue_mem[wr_ptr_reg + 2'(k)] <= packed_item[k];
            end
        end
    end

endmodule

`default_nettype wire
